/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the heap queue checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define MMH_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("heap queue assertion failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define MMH_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("heap queue assertion failed");

`endif

/* hw/rtl/mmh_pkg.sv */
// ----------------------------------------------------------------------------
// Min-max heap package
// Shared types, codes and compare functions for the heap queue.
// ----------------------------------------------------------------------------
`default_nettype none

package mmh_pkg;

    localparam int DEFAULT_CAPACITY = 1024;

    typedef enum logic [1:0] {
        OP_PUSH    = 2'd0,
        OP_POP_MIN = 2'd1,
        OP_POP_MAX = 2'd2,
        OP_NONE    = 2'd3
    } op_kind_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic signed [31:0] key;
        logic signed [31:0] val;
    } entry_t;

    typedef struct packed {
        op_kind_t kind;
        entry_t   entry;
    } cmd_t;

    // Order by key, then by value.
    function automatic logic entry_less(input entry_t a, input entry_t b);
        logic res;
        if (a.key != b.key)
            res = (a.key < b.key);
        else
            res = (a.val < b.val);
        return res;
    endfunction

    // True when a belongs above b on a min level (or a max level when is_max).
    function automatic logic entry_better(input entry_t a, input entry_t b,
                                          input logic is_max);
        logic res;
        if (is_max)
            res = entry_less(b, a);
        else
            res = entry_less(a, b);
        return res;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/mmh_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mmh_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1025
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/mmh_front.sv */
// ----------------------------------------------------------------------------
// Heap queue front end
// Accepts operations, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none

module mmh_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic [1:0]         op,
    input  wire logic signed [31:0] key,
    input  wire logic signed [31:0] payload,
    output logic                    cmd_valid,
    output mmh_pkg::cmd_t           cmd,
    input  wire logic               cmd_ready
);

    mmh_pkg::cmd_t slot_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    fill_reg, fill_next;
    logic          do_wr, do_rd;
    mmh_pkg::cmd_t in_cmd;

    always_comb
    begin
        unique case (op)
            2'd0:    in_cmd.kind = mmh_pkg::OP_PUSH;
            2'd1:    in_cmd.kind = mmh_pkg::OP_POP_MIN;
            2'd2:    in_cmd.kind = mmh_pkg::OP_POP_MAX;
            default: in_cmd.kind = mmh_pkg::OP_NONE;
        endcase
        in_cmd.entry.key = key;
        in_cmd.entry.val = payload;
    end

    assign full      = (fill_reg == 2'd2);
    assign cmd_valid = (fill_reg != 2'd0);
    assign cmd       = slot_reg[rd_ptr_reg];
    assign do_wr     = push && !full;
    assign do_rd     = cmd_valid && cmd_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_wr;
        rd_ptr_next = rd_ptr_reg ^ do_rd;
        fill_next   = fill_reg + {1'b0, do_wr} - {1'b0, do_rd};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/mmh_engine.sv */
// ----------------------------------------------------------------------------
// Heap queue engine
// Carries out push, pop-min and pop-max on the heap memory, one at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module mmh_engine #(
    parameter int CAPACITY = mmh_pkg::DEFAULT_CAPACITY
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cmd_valid,
    input  wire mmh_pkg::cmd_t                     cmd,
    output logic                                   cmd_ready,
    output logic                                   res_valid,
    input  wire logic                              res_pop,
    output logic signed [31:0]                     res_payload,
    output logic [1:0]                             res_status,
    output logic [$clog2(CAPACITY+1)-1:0]          res_count
);

    localparam int AW = $clog2(CAPACITY + 1);
    localparam int XW = AW + 2;
    localparam logic [2:0] NUM_CAND = 3'd6;

    typedef enum logic [3:0] {
        S_IDLE, S_TOP, S_MAX2, S_MAX3, S_LAST, S_LEVEL, S_SCAN, S_EVAL, S_FIX,
        S_UP, S_CLIMB_REQ, S_CLIMB
    } state_t;

    typedef enum logic [1:0] {
        SK_NONE, SK_CHILD, SK_GRAND
    } sift_kind_t;

    state_t                state_reg, state_next;
    logic [AW-1:0]         idx_reg, idx_next;
    logic [AW-1:0]         cnt_reg, cnt_next;
    logic [AW-1:0]         m_reg, m_next;
    logic [2:0]            k_reg, k_next;
    sift_kind_t            kind_reg, kind_next;
    logic                  is_max_reg, is_max_next;
    logic                  swap_reg, swap_next;
    mmh_pkg::entry_t       cur_reg, cur_next;
    mmh_pkg::entry_t       best_reg, best_next;
    mmh_pkg::entry_t       c0_reg, c0_next;
    mmh_pkg::entry_t       c1_reg, c1_next;
    logic signed [31:0]    ret_reg, ret_next;
    logic                  res_valid_reg, res_valid_next;
    logic signed [31:0]    res_payload_reg, res_payload_next;
    mmh_pkg::status_t      res_status_reg, res_status_next;
    logic [AW-1:0]         res_count_reg, res_count_next;

    logic                  wr_en, rd_en;
    logic [AW-1:0]         wr_addr, rd_addr;
    mmh_pkg::entry_t       wr_data, rd_data;

    logic                  lvl_odd;
    logic                  take;
    logic [AW-1:0]         pidx;
    logic signed [31:0]    pval;
    logic [XW-1:0]         cand_k, cand_n, cand_0;
    mmh_pkg::entry_t       pe;
    logic                  cond;

    mmh_ram #(
        .WIDTH ($bits(mmh_pkg::entry_t)),
        .DEPTH (CAPACITY + 1)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    function automatic logic [XW-1:0] cand_addr(input logic [AW-1:0] i, input logic [2:0] k);
        logic [XW-1:0] a;
        if (k < 3'd2)
            a = {1'b0, i, 1'b0} + XW'(k);
        else
            a = {i, 2'b00} + XW'(k - 3'd2);
        return a;
    endfunction

    // Level of a slot is the position of its top set bit; odd levels are max levels.
    always_comb
    begin
        lvl_odd = 1'b0;
        for (int b = 0; b < AW; b++)
        begin
            if (idx_reg[b])
                lvl_odd = b[0];
        end
    end

    assign cmd_ready   = (state_reg == S_IDLE) && !res_valid_reg;
    assign res_valid   = res_valid_reg;
    assign res_payload = res_payload_reg;
    assign res_status  = res_status_reg;
    assign res_count   = res_count_reg;

    always_comb
    begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        cnt_next         = cnt_reg;
        m_next           = m_reg;
        k_next           = k_reg;
        kind_next        = kind_reg;
        is_max_next      = is_max_reg;
        swap_next        = swap_reg;
        cur_next         = cur_reg;
        best_next        = best_reg;
        c0_next          = c0_reg;
        c1_next          = c1_reg;
        ret_next         = ret_reg;
        res_valid_next   = res_valid_reg && !res_pop;
        res_payload_next = res_payload_reg;
        res_status_next  = res_status_reg;
        res_count_next   = res_count_reg;
        wr_en            = 1'b0;
        wr_addr          = idx_reg;
        wr_data          = cur_reg;
        rd_en            = 1'b0;
        rd_addr          = idx_reg;
        take             = 1'b0;
        pidx             = idx_reg;
        pval             = rd_data.val;
        cand_k           = cand_addr(idx_reg, k_reg);
        cand_n           = cand_addr(idx_reg, k_reg + 3'd1);
        cand_0           = cand_addr(idx_reg, 3'd0);
        pe               = m_reg[1] ? c1_reg : c0_reg;
        cond             = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && !res_valid_reg)
                begin
                    ret_next         = '0;
                    res_status_next  = mmh_pkg::STATUS_OK;
                    res_payload_next = '0;
                    res_count_next   = cnt_reg;
                    unique case (cmd.kind)
                        mmh_pkg::OP_PUSH:
                        begin
                            if (cnt_reg == AW'(CAPACITY))
                            begin
                                res_status_next = mmh_pkg::STATUS_FULL;
                                res_valid_next  = 1'b1;
                            end
                            else
                            begin
                                cnt_next = cnt_reg + 1'b1;
                                idx_next = cnt_reg + 1'b1;
                                cur_next = cmd.entry;
                                if (cnt_reg == '0)
                                begin
                                    wr_en          = 1'b1;
                                    wr_addr        = AW'(1);
                                    wr_data        = cmd.entry;
                                    res_count_next = AW'(1);
                                    res_valid_next = 1'b1;
                                end
                                else
                                begin
                                    rd_en      = 1'b1;
                                    rd_addr    = AW'(cnt_reg + 1'b1) >> 1;
                                    state_next = S_UP;
                                end
                            end
                        end
                        mmh_pkg::OP_POP_MIN, mmh_pkg::OP_POP_MAX:
                        begin
                            is_max_next = (cmd.kind == mmh_pkg::OP_POP_MAX);
                            if (cnt_reg == '0)
                            begin
                                res_status_next = mmh_pkg::STATUS_EMPTY;
                                res_valid_next  = 1'b1;
                            end
                            else if (cmd.kind == mmh_pkg::OP_POP_MIN || cnt_reg == AW'(1))
                            begin
                                idx_next   = AW'(1);
                                rd_en      = 1'b1;
                                rd_addr    = AW'(1);
                                state_next = S_TOP;
                            end
                            else
                            begin
                                idx_next   = AW'(2);
                                rd_en      = 1'b1;
                                rd_addr    = AW'(2);
                                state_next = (cnt_reg == AW'(2)) ? S_TOP : S_MAX2;
                            end
                        end
                        default:
                        begin
                            res_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            S_MAX2:
            begin
                c0_next    = rd_data;
                rd_en      = 1'b1;
                rd_addr    = AW'(3);
                state_next = S_MAX3;
            end
            S_TOP, S_MAX3:
            begin
                take = 1'b1;
                if (state_reg == S_MAX3)
                begin
                    // Only keys decide here; a key tie takes slot 3.
                    if (c0_reg.key > rd_data.key)
                    begin
                        pidx = AW'(2);
                        pval = c0_reg.val;
                    end
                    else
                    begin
                        pidx = AW'(3);
                        pval = rd_data.val;
                    end
                end
            end
            S_LAST:
            begin
                cur_next   = rd_data;
                state_next = S_LEVEL;
            end
            S_LEVEL:
            begin
                if (cand_0 > XW'(cnt_reg))
                begin
                    wr_en            = 1'b1;
                    res_payload_next = ret_reg;
                    res_count_next   = cnt_reg;
                    res_valid_next   = 1'b1;
                    state_next       = S_IDLE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = cand_0[AW-1:0];
                    k_next     = 3'd0;
                    best_next  = cur_reg;
                    kind_next  = SK_NONE;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (mmh_pkg::entry_better(rd_data, best_reg, is_max_reg))
                begin
                    best_next = rd_data;
                    m_next    = cand_k[AW-1:0];
                    kind_next = (k_reg < 3'd2) ? SK_CHILD : SK_GRAND;
                end
                if (k_reg == 3'd0)
                    c0_next = rd_data;
                if (k_reg == 3'd1)
                    c1_next = rd_data;
                if ((k_reg + 3'd1 < NUM_CAND) && (cand_n <= XW'(cnt_reg)))
                begin
                    rd_en   = 1'b1;
                    rd_addr = cand_n[AW-1:0];
                    k_next  = k_reg + 3'd1;
                end
                else
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                wr_en = 1'b1;
                unique case (kind_reg)
                    SK_CHILD:
                    begin
                        wr_data    = best_reg;
                        state_next = S_FIX;
                    end
                    SK_GRAND:
                    begin
                        wr_data    = best_reg;
                        swap_next  = mmh_pkg::entry_better(pe, cur_reg, is_max_reg);
                        state_next = S_FIX;
                    end
                    default:
                    begin
                        res_payload_next = ret_reg;
                        res_count_next   = cnt_reg;
                        res_valid_next   = 1'b1;
                        state_next       = S_IDLE;
                    end
                endcase
            end
            S_FIX:
            begin
                if (kind_reg == SK_CHILD)
                begin
                    wr_en            = 1'b1;
                    wr_addr          = m_reg;
                    res_payload_next = ret_reg;
                    res_count_next   = cnt_reg;
                    res_valid_next   = 1'b1;
                    state_next       = S_IDLE;
                end
                else
                begin
                    if (swap_reg)
                    begin
                        wr_en    = 1'b1;
                        wr_addr  = m_reg >> 1;
                        cur_next = pe;
                    end
                    idx_next   = m_reg;
                    state_next = S_LEVEL;
                end
            end
            S_UP:
            begin
                if (!lvl_odd)
                    cond = mmh_pkg::entry_less(rd_data, cur_reg);
                else
                    cond = mmh_pkg::entry_less(cur_reg, rd_data);
                is_max_next = lvl_odd ? !cond : cond;
                if (cond)
                begin
                    wr_en    = 1'b1;
                    wr_data  = rd_data;
                    idx_next = idx_reg >> 1;
                end
                state_next = S_CLIMB_REQ;
            end
            S_CLIMB_REQ:
            begin
                if (idx_reg >= AW'(4))
                begin
                    rd_en      = 1'b1;
                    rd_addr    = idx_reg >> 2;
                    state_next = S_CLIMB;
                end
                else
                begin
                    wr_en            = 1'b1;
                    res_payload_next = '0;
                    res_count_next   = cnt_reg;
                    res_valid_next   = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            S_CLIMB:
            begin
                wr_en = 1'b1;
                if (mmh_pkg::entry_better(cur_reg, rd_data, is_max_reg))
                begin
                    wr_data    = rd_data;
                    idx_next   = idx_reg >> 2;
                    state_next = S_CLIMB_REQ;
                end
                else
                begin
                    res_payload_next = '0;
                    res_count_next   = cnt_reg;
                    res_valid_next   = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Removal of the chosen slot, shared by both pop flavors.
        if (take)
        begin
            ret_next = pval;
            idx_next = pidx;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg > pidx)
            begin
                rd_en      = 1'b1;
                rd_addr    = cnt_reg;
                state_next = S_LAST;
            end
            else
            begin
                res_payload_next = pval;
                res_count_next   = cnt_reg - 1'b1;
                res_valid_next   = 1'b1;
                state_next       = S_IDLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            res_valid_reg  <= 1'b0;
            res_status_reg <= mmh_pkg::STATUS_OK;
            res_count_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            res_valid_reg  <= res_valid_next;
            res_status_reg <= res_status_next;
            res_count_reg  <= res_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg         <= idx_next;
        m_reg           <= m_next;
        k_reg           <= k_next;
        kind_reg        <= kind_next;
        is_max_reg      <= is_max_next;
        swap_reg        <= swap_next;
        cur_reg         <= cur_next;
        best_reg        <= best_next;
        c0_reg          <= c0_next;
        c1_reg          <= c1_next;
        ret_reg         <= ret_next;
        res_payload_reg <= res_payload_next;
    end

endmodule

`default_nettype wire

/* hw/rtl/min_max_heap_priority_queue.sv */
// ----------------------------------------------------------------------------
// Min-max heap priority queue
// Double-ended priority queue of (key, payload) entries with queue handshakes.
// ----------------------------------------------------------------------------
// Each operation takes a push, a pop of the smallest entry or a pop of the
// largest entry and returns exactly one result: the removed payload, a status,
// the entry count and an empty flag. A two-entry command queue takes new
// operations while the engine works, and a result register holds the finished
// result until it is transferred out. Operations run one at a time on a heap
// memory with one write port and one registered read port, one entry read per
// cycle. A push sifts the new entry up through parent and grandparent slots; a
// pop sifts the last entry down from the removed slot by grandchild levels.
// The default capacity is 1024. No clearing pass is needed after reset
// because only written slots are ever read.
`default_nettype none

module min_max_heap_priority_queue #(
    parameter int CAPACITY = mmh_pkg::DEFAULT_CAPACITY
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              push,
    output logic                                   full,
    input  wire logic [1:0]                        op,
    input  wire logic signed [31:0]                key,
    input  wire logic signed [31:0]                payload,
    output logic                                   empty,
    input  wire logic                              pop,
    output logic signed [31:0]                     popped_payload,
    output logic [1:0]                             status,
    output logic [$clog2(CAPACITY+1)-1:0]          entry_count,
    output logic                                   empty_flag
);

    // Commands queued between the front end and the engine.
    logic          cmd_valid;
    logic          cmd_ready;
    mmh_pkg::cmd_t cmd;
    logic          res_valid;

    mmh_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .op        (op),
        .key       (key),
        .payload   (payload),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_ready (cmd_ready)
    );

    mmh_engine #(
        .CAPACITY (CAPACITY)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_ready   (cmd_ready),
        .res_valid   (res_valid),
        .res_pop     (pop),
        .res_payload (popped_payload),
        .res_status  (status),
        .res_count   (entry_count)
    );

    // A result is waiting whenever the result register is loaded.
    assign empty      = !res_valid;
    assign empty_flag = (entry_count == '0);

endmodule

`default_nettype wire

/* hw/rtl/mmh_checker.sv */
// ----------------------------------------------------------------------------
// Heap queue checker
// Port-level assertions on results of the min-max heap queue.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module mmh_checker #(
    parameter int CAPACITY = mmh_pkg::DEFAULT_CAPACITY
) (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              push,
    input wire logic                              full,
    input wire logic [1:0]                        op,
    input wire logic signed [31:0]                key,
    input wire logic signed [31:0]                payload,
    input wire logic                              empty,
    input wire logic                              pop,
    input wire logic signed [31:0]                popped_payload,
    input wire logic [1:0]                        status,
    input wire logic [$clog2(CAPACITY+1)-1:0]     entry_count,
    input wire logic                              empty_flag
);

    `MMH_ASSERT_IMPL(a_flag_matches_count, !empty, empty_flag == (entry_count == '0))
    `MMH_ASSERT_IMPL(a_full_at_capacity, !empty && status == mmh_pkg::STATUS_FULL, entry_count == ($clog2(CAPACITY+1))'(CAPACITY) && popped_payload == '0)
    `MMH_ASSERT_IMPL(a_empty_pop_clean, !empty && status == mmh_pkg::STATUS_EMPTY, entry_count == '0 && popped_payload == '0)
    `MMH_ASSERT_NEXT(a_result_holds, !empty && !pop, !empty && $stable(popped_payload) && $stable(entry_count))

endmodule

bind min_max_heap_priority_queue mmh_checker #(.CAPACITY(CAPACITY)) u_checker (.*);

`default_nettype wire
